/* rtl/core/xzp_pkg.sv */
// ----------------------------------------------------------------------------
// xzp_pkg
// Types and constants shared by the index size parser modules.
// ----------------------------------------------------------------------------
package xzp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned SIZE_W  = 63;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned SHAMT_W = 7;

  typedef enum logic [1:0] {
    PH_IND    = 2'd0,
    PH_COUNT  = 2'd1,
    PH_UNPAD  = 2'd2,
    PH_UNCOMP = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INDICATOR = 2'd1,
    ST_MALFORMED = 2'd2
  } status_e;

  typedef struct packed {
    logic [SIZE_W-1:0] total_size;
    status_e           status;
  } result_t;

endpackage

/* rtl/core/xz_index_size_parser_top.sv */
// ----------------------------------------------------------------------------
// xz_index_size_parser_top
// XZ index size parser: takes index bytes one per request and returns the
// saturating sum of the uncompressed sizes, or an error status.
// ----------------------------------------------------------------------------
// One index byte is taken per cycle while the pipeline does not halt. Each
// byte passes an input register, the parsing logic and a result register,
// which holds the result of the byte that ends the last record or shows an
// error. The pipeline only halts while a result waits in the result register
// and the downstream side stalls.
module xz_index_size_parser_top import xzp_pkg::*; #(
  parameter int unsigned MAX_NUMBER_BYTES = 9
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [BYTE_W-1:0] index_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [SIZE_W-1:0] total_size_o,
  output logic [1:0]        status_o
);

  logic              advance;
  logic              byte_valid;
  logic [BYTE_W-1:0] byte_q;
  logic              res_valid;
  result_t           res;

  xzp_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .index_byte_i (index_byte_i),
    .advance_i    (advance),
    .valid_o      (byte_valid),
    .byte_o       (byte_q)
  );

  xzp_parse #(
    .MAX_NUMBER_BYTES (MAX_NUMBER_BYTES)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (byte_valid),
    .byte_i      (byte_q),
    .advance_i   (advance),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  xzp_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_valid_i  (res_valid),
    .res_i        (res),
    .advance_o    (advance),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .total_size_o (total_size_o),
    .status_o     (status_o)
  );

endmodule

/* rtl/core/xzp_in_reg.sv */
// ----------------------------------------------------------------------------
// xzp_in_reg
// Input register: holds one index byte until the parser takes it.
// ----------------------------------------------------------------------------
module xzp_in_reg import xzp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [BYTE_W-1:0] index_byte_i,
  input  logic              advance_i,
  output logic              valid_o,
  output logic [BYTE_W-1:0] byte_o
);

  logic              valid_q, valid_d;
  logic [BYTE_W-1:0] byte_q;
  logic              load;

  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load ? 1'b1 : (advance_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= index_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

/* rtl/core/xzp_parse.sv */
// ----------------------------------------------------------------------------
// xzp_parse
// Parser state and per-byte logic: multibyte integer assembly, record
// counting and saturating size sum. Gives at most one result per byte.
// ----------------------------------------------------------------------------
module xzp_parse import xzp_pkg::*; #(
  parameter int unsigned MAX_NUMBER_BYTES = 9
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [BYTE_W-1:0] byte_i,
  input  logic              advance_i,
  output logic              res_valid_o,
  output result_t           res_o
);

  localparam logic [POS_W:0] MaxPos = (POS_W+1)'(MAX_NUMBER_BYTES);

  phase_e            phase_q, phase_d;
  logic [SIZE_W-1:0] accum_q, accum_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [SIZE_W-1:0] records_q, records_d;
  logic [SIZE_W-1:0] total_q, total_d;

  logic [SHAMT_W-1:0] shamt;
  logic [SIZE_W-1:0]  accum_new;
  logic [SIZE_W:0]    sum;
  logic [SIZE_W-1:0]  sum_sat;
  logic [POS_W:0]     pos_inc;

  assign shamt     = SHAMT_W'({pos_q, 3'b000}) - SHAMT_W'(pos_q);
  assign accum_new = accum_q | (SIZE_W'(byte_i[6:0]) << shamt);
  assign sum       = {1'b0, total_q} + {1'b0, accum_new};
  assign sum_sat   = sum[SIZE_W] ? {SIZE_W{1'b1}} : sum[SIZE_W-1:0];
  assign pos_inc   = {1'b0, pos_q} + (POS_W+1)'(1);

  always_comb begin
    phase_d          = phase_q;
    accum_d          = accum_q;
    pos_d            = pos_q;
    records_d        = records_q;
    total_d          = total_q;
    res_valid_o      = 1'b0;
    res_o.total_size = '0;
    res_o.status     = ST_OK;

    if (valid_i) begin
      if (phase_q == PH_IND) begin
        if (byte_i != '0) begin
          res_valid_o  = 1'b1;
          res_o.status = ST_INDICATOR;
        end else begin
          phase_d = PH_COUNT;
          accum_d = '0;
          pos_d   = '0;
        end
      end else if (pos_q != '0 && byte_i == '0) begin
        res_valid_o  = 1'b1;
        res_o.status = ST_MALFORMED;
      end else if (byte_i[7]) begin
        if (pos_inc >= MaxPos) begin
          res_valid_o  = 1'b1;
          res_o.status = ST_MALFORMED;
        end else begin
          accum_d = accum_new;
          pos_d   = pos_inc[POS_W-1:0];
        end
      end else begin
        accum_d = '0;
        pos_d   = '0;
        case (phase_q)
          PH_COUNT: begin
            records_d = accum_new;
            if (accum_new == '0) begin
              res_valid_o = 1'b1;
            end else begin
              phase_d = PH_UNPAD;
            end
          end
          PH_UNPAD: begin
            phase_d = PH_UNCOMP;
          end
          PH_UNCOMP: begin
            total_d   = sum_sat;
            records_d = records_q - SIZE_W'(1);
            if (records_q == SIZE_W'(1)) begin
              res_valid_o      = 1'b1;
              res_o.total_size = sum_sat;
            end else begin
              phase_d = PH_UNPAD;
            end
          end
          default: begin
            phase_d = PH_IND;
          end
        endcase
      end

      // any result restarts the parser
      if (res_valid_o) begin
        phase_d   = PH_IND;
        accum_d   = '0;
        pos_d     = '0;
        records_d = '0;
        total_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IND;
      accum_q   <= '0;
      pos_q     <= '0;
      records_q <= '0;
      total_q   <= '0;
    end else if (advance_i) begin
      phase_q   <= phase_d;
      accum_q   <= accum_d;
      pos_q     <= pos_d;
      records_q <= records_d;
      total_q   <= total_d;
    end
  end

endmodule

/* rtl/core/xzp_out_reg.sv */
// ----------------------------------------------------------------------------
// xzp_out_reg
// Result register: holds a result until the downstream side takes it.
// ----------------------------------------------------------------------------
module xzp_out_reg import xzp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  result_t           res_i,
  output logic              advance_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [SIZE_W-1:0] total_size_o,
  output logic [1:0]        status_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign advance_o = !valid_q || !out_stall_i;
  assign valid_d   = advance_o ? res_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign total_size_o = res_q.total_size;
  assign status_o     = res_q.status;

endmodule

/* sim/tb_xz_index_size_parser_top.sv */
// ----------------------------------------------------------------------------
// tb_xz_index_size_parser_top
// Self-checking bench for the XZ index size parser. Index byte streams are
// queued and driven with random gaps. A local parser works out the expected
// sum and status from the accepted bytes. A monitor checks each returned
// result against the oldest expected one.
// ----------------------------------------------------------------------------
module tb_xz_index_size_parser_top;
  import xzp_pkg::*;

  localparam int unsigned     MAX_BYTES    = 9;
  localparam logic [SIZE_W-1:0] TOTAL_MAX  = '1;
  localparam int unsigned     CYCLE_LIMIT  = 200000;
  localparam int unsigned     DRAIN_CYCLES = 4;
  localparam int unsigned     HOLD_CYCLES  = 300;
  localparam int unsigned     LIGHT_PCT    = 12;
  localparam int unsigned     HEAVY_PCT    = 73;

  typedef enum logic [1:0] {
    IDLE_SEND_LIGHT,
    IDLE_SEND_HEAVY,
    IDLE_NONE
  } idle_mode_e;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              in_valid_i   = 1'b0;
  logic              in_stall_o;
  logic [BYTE_W-1:0] index_byte_i = '0;
  logic              out_valid_o;
  logic              out_stall_i  = 1'b0;
  logic [SIZE_W-1:0] total_size_o;
  logic [1:0]        status_o;

  xz_index_size_parser_top #(
    .MAX_NUMBER_BYTES(MAX_BYTES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .index_byte_i (index_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .total_size_o (total_size_o),
    .status_o     (status_o)
  );

  always #5 clk_i = ~clk_i;

  logic [BYTE_W-1:0] index_bytes_q[$];
  result_t           index_results_q[$];
  idle_mode_e        idle_mode  = IDLE_SEND_LIGHT;
  logic              stall_hold = 1'b0;
  logic              byte_taken = 1'b0;
  int unsigned       cycle_cnt  = 0;
  int                n_offered  = 0;
  int                n_accepted = 0;
  int                n_errors   = 0;
  int                n_ok       = 0;
  int                n_indicator = 0;
  int                n_malformed = 0;

  // local parser state
  phase_e            prs_phase   = PH_IND;
  logic [SIZE_W-1:0] prs_accum   = '0;
  logic [POS_W-1:0]  prs_pos     = '0;
  logic [SIZE_W-1:0] prs_records = '0;
  logic [SIZE_W-1:0] prs_total   = '0;

  task automatic queue_index_result(input logic [SIZE_W-1:0] total, input status_e st);
    index_results_q.push_back('{total_size: total, status: st});
    prs_phase   = PH_IND;
    prs_accum   = '0;
    prs_pos     = '0;
    prs_records = '0;
    prs_total   = '0;
  endtask

  task automatic parse_index_byte(input logic [BYTE_W-1:0] b);
    logic [SIZE_W-1:0] num;
    if (prs_phase == PH_IND) begin
      if (b != 8'h00) begin
        queue_index_result('0, ST_INDICATOR);
      end else begin
        prs_phase = PH_COUNT;
        prs_accum = '0;
        prs_pos   = '0;
      end
      return;
    end
    if (prs_pos > 0 && b == 8'h00) begin
      queue_index_result('0, ST_MALFORMED);
      return;
    end
    if (prs_pos < MAX_BYTES) prs_accum = prs_accum | (SIZE_W'(b[6:0]) << (7 * prs_pos));
    if (b[7]) begin
      if (prs_pos + 1 >= MAX_BYTES) begin
        queue_index_result('0, ST_MALFORMED);
      end else begin
        prs_pos = prs_pos + 1'b1;
      end
      return;
    end
    num       = prs_accum;
    prs_accum = '0;
    prs_pos   = '0;
    case (prs_phase)
      PH_COUNT: begin
        prs_records = num;
        if (num == '0) queue_index_result('0, ST_OK);
        else prs_phase = PH_UNPAD;
      end
      PH_UNPAD: begin
        prs_phase = PH_UNCOMP;
      end
      default: begin
        if (num > TOTAL_MAX - prs_total) prs_total = TOTAL_MAX;
        else prs_total = prs_total + num;
        prs_records = prs_records - 1'b1;
        if (prs_records == '0) queue_index_result(prs_total, ST_OK);
        else prs_phase = PH_UNPAD;
      end
    endcase
  endtask

  function automatic bit sender_idles();
    case (idle_mode)
      IDLE_SEND_LIGHT: return $urandom_range(0, 99) < LIGHT_PCT;
      IDLE_SEND_HEAVY: return $urandom_range(0, 99) < HEAVY_PCT;
      default:         return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_idles();
    case (idle_mode)
      IDLE_SEND_LIGHT: return $urandom_range(0, 99) < HEAVY_PCT;
      IDLE_SEND_HEAVY: return $urandom_range(0, 99) < LIGHT_PCT;
      default:         return 1'b0;
    endcase
  endfunction

  always @(negedge clk_i) begin : byte_driver
    if (rst_ni && (!in_valid_i || byte_taken)) begin
      if (index_bytes_q.size() > 0 && !sender_idles()) begin
        in_valid_i   <= 1'b1;
        index_byte_i <= index_bytes_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : stall_driver
    out_stall_i <= stall_hold || receiver_idles();
  end

  always @(posedge clk_i) begin : result_monitor
    result_t want;
    if (!rst_ni) begin
      byte_taken = 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (index_results_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("ERROR: unexpected result total_size=%0d status=%0d",
                     total_size_o, status_o);
        end else begin
          want = index_results_q.pop_front();
          case (want.status)
            ST_OK:        n_ok++;
            ST_INDICATOR: n_indicator++;
            default:      n_malformed++;
          endcase
          if (total_size_o !== want.total_size || status_o !== want.status) begin
            n_errors++;
            if (n_errors <= 10)
              $display("ERROR: result mismatch exp total_size=%0d status=%0d, got %0d %0d",
                       want.total_size, want.status, total_size_o, status_o);
          end
        end
      end
      byte_taken = in_valid_i && !in_stall_o;
      if (byte_taken) begin
        n_accepted++;
        parse_index_byte(index_byte_i);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic offer_byte(input logic [BYTE_W-1:0] b);
    index_bytes_q.push_back(b);
    n_offered++;
  endtask

  task automatic put_number(input logic [SIZE_W-1:0] v);
    logic [BYTE_W-1:0] b;
    do begin
      b = {1'b0, v[6:0]};
      v = v >> 7;
      if (v != '0) b[7] = 1'b1;
      offer_byte(b);
    end while (v != '0);
  endtask

  // zero continuation byte or a number that runs past the byte limit
  task automatic put_broken_number();
    int n;
    if ($urandom_range(0, 1)) begin
      n = $urandom_range(1, MAX_BYTES - 1);
      repeat (n) offer_byte(8'h80 | 8'($urandom_range(0, 127)));
      offer_byte(8'h00);
    end else begin
      repeat (MAX_BYTES) offer_byte(8'h80 | 8'($urandom_range(0, 127)));
    end
  endtask

  function automatic logic [SIZE_W-1:0] rand_size();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0:       return SIZE_W'($urandom_range(0, 127));
      1:       return SIZE_W'($urandom_range(128, 1 << 21));
      2:       return r[SIZE_W-1:0] >> $urandom_range(0, SIZE_W - 1);
      default: return TOTAL_MAX - SIZE_W'($urandom_range(0, 3));
    endcase
  endfunction

  task automatic put_random_stream();
    int kind;
    int recs;
    int bad;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 4)) offer_byte(8'($urandom_range(0, 255)));
    end else if (kind < 14) begin
      offer_byte(8'($urandom_range(1, 255)));
    end else begin
      recs = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 5);
      bad  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2 * recs) : -1;
      offer_byte(8'h00);
      for (int slot = 0; slot <= 2 * recs; slot++) begin
        if (slot == bad) begin
          put_broken_number();
          return;
        end
        if (slot == 0) put_number(SIZE_W'(recs));
        else put_number(rand_size());
      end
    end
  endtask

  task automatic queue_random_bytes(input int n);
    int start;
    start = n_offered;
    while (n_offered - start < n) put_random_stream();
  endtask

  task automatic wait_drained();
    while (index_bytes_q.size() != 0 || in_valid_i || index_results_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // saturating sum of two records (first at field maximum), one record, bad indicator, no records, two bad numbers
    offer_byte(8'h00); offer_byte(8'h02);
    offer_byte(8'h01); put_number(TOTAL_MAX);
    offer_byte(8'h01); offer_byte(8'h01);
    offer_byte(8'h00); offer_byte(8'h01); offer_byte(8'h00); offer_byte(8'h7F);
    offer_byte(8'hFF);
    offer_byte(8'h00); offer_byte(8'h00);
    offer_byte(8'h00); offer_byte(8'h81); offer_byte(8'h00);
    offer_byte(8'h00);
    repeat (MAX_BYTES) offer_byte(8'hFF);
    wait_drained();

    idle_mode = IDLE_SEND_LIGHT;
    queue_random_bytes(700);
    wait_drained();

    idle_mode = IDLE_SEND_HEAVY;
    queue_random_bytes(700);
    wait_drained();

    // long downstream hold while bytes keep coming
    idle_mode = IDLE_NONE;
    queue_random_bytes(600);
    stall_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    stall_hold = 1'b0;
    wait_drained();

    repeat (8) @(posedge clk_i);
    n_errors += index_results_q.size();
    $display("Accepted %0d index bytes over three idle mixes and a long output hold.",
             n_accepted);
    $display("Results checked: %0d ok, %0d bad indicator, %0d malformed integer.",
             n_ok, n_indicator, n_malformed);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/xzp_pkg.sv
rtl/core/xzp_in_reg.sv
rtl/core/xzp_parse.sv
rtl/core/xzp_out_reg.sv
rtl/core/xz_index_size_parser_top.sv
sim/tb_xz_index_size_parser_top.sv
